// ===== hdl/pid_hd_pkg.sv =====
// Shared types, constants and register codes for the PID heater drive core.
package pid_hd_pkg;

  localparam int unsigned GainW   = 16;
  localparam int unsigned FloorW  = 10;
  localparam int unsigned MeasW   = 16;
  localparam int unsigned TargetW = 9;
  localparam int unsigned DriveW  = 10;
  localparam int unsigned ErrW    = 17;
  localparam int unsigned PrevW   = 18;
  localparam int unsigned IntegW  = 24;
  localparam int unsigned FracW   = 12;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgDataW = 16;
  localparam int unsigned InDataW  = 32;
  localparam int unsigned OutDataW = 16;

  localparam logic signed [GainW-1:0] GainPReset  = 16'sd5120;
  localparam logic signed [GainW-1:0] GainIReset  = 16'sd0;
  localparam logic signed [GainW-1:0] GainDReset  = 16'sd5120;
  localparam logic [FloorW-1:0]       FloorReset  = 10'd0;

  localparam logic signed [IntegW-1:0] IntegLimit = 24'sd4096000;
  localparam logic [DriveW-1:0]        DriveMax   = 10'd1023;
  // 1023.0 in Q.12.
  localparam logic signed [36:0]       DriveFull  = 37'sd4190208;

  typedef enum logic [CfgIdxW-1:0] {
    REG_GAIN_P      = 2'd0,
    REG_GAIN_I      = 2'd1,
    REG_GAIN_D      = 2'd2,
    REG_DRIVE_FLOOR = 2'd3
  } cfg_reg_e;

  typedef struct packed {
    logic signed [GainW-1:0] gain_p;
    logic signed [GainW-1:0] gain_i;
    logic signed [GainW-1:0] gain_d;
    logic [FloorW-1:0]       drive_floor;
  } cfg_t;

endpackage

// ===== hdl/pid_hd_cfg.sv =====
// Configuration register file for the PID heater drive core.
module pid_hd_cfg import pid_hd_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  output cfg_t                cfg_o
);

  cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.gain_p      <= GainPReset;
      cfg_q.gain_i      <= GainIReset;
      cfg_q.gain_d      <= GainDReset;
      cfg_q.drive_floor <= FloorReset;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        REG_GAIN_P:      cfg_q.gain_p      <= $signed(cfg_data_i[GainW-1:0]);
        REG_GAIN_I:      cfg_q.gain_i      <= $signed(cfg_data_i[GainW-1:0]);
        REG_GAIN_D:      cfg_q.gain_d      <= $signed(cfg_data_i[GainW-1:0]);
        REG_DRIVE_FLOOR: cfg_q.drive_floor <= cfg_data_i[FloorW-1:0];
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ===== hdl/pid_hd_law.sv =====
// Combinational PID control law: error, three products, integrator clamp and drive.
module pid_hd_law import pid_hd_pkg::*; (
  input  cfg_t                      cfg_i,
  input  logic signed [MeasW-1:0]   meas_i,
  input  logic [TargetW-1:0]        target_i,
  input  logic signed [IntegW-1:0]  integ_i,
  input  logic signed [PrevW-1:0]   prev_err_i,
  output logic signed [IntegW-1:0]  integ_o,
  output logic signed [PrevW-1:0]   err_o,
  output logic [DriveW-1:0]         drive_o
);

  logic signed [ErrW-1:0] err;
  logic signed [PrevW-1:0] derr;
  logic signed [32:0] p_prod;
  logic signed [32:0] i_prod;
  logic signed [33:0] d_prod;
  logic signed [34:0] u_int;
  logic signed [35:0] u_sum;
  logic signed [36:0] diff;
  logic [DriveW-1:0]  quot;

  // Setpoint is whole degrees, so scale it to Q.4 before subtracting.
  assign err  = $signed({4'b0000, target_i, 4'b0000}) - $signed({meas_i[MeasW-1], meas_i});
  assign derr = $signed({err[ErrW-1], err}) - prev_err_i;

  assign p_prod = 33'(cfg_i.gain_p) * 33'(err);
  assign i_prod = 33'(cfg_i.gain_i) * 33'(err);
  assign d_prod = 34'(cfg_i.gain_d) * 34'(derr);

  assign u_int = 35'(integ_i) + 35'(i_prod);
  assign u_sum = 36'(u_int) + 36'(p_prod) + 36'(d_prod);
  assign diff  = DriveFull - 37'(u_sum);
  assign quot  = diff[FracW+DriveW-1:FracW];

  always_comb begin
    priority if (u_int > 35'(IntegLimit)) begin
      integ_o = IntegLimit;
    end else if (u_int < -35'(IntegLimit)) begin
      integ_o = -IntegLimit;
    end else begin
      integ_o = u_int[IntegW-1:0];
    end
  end

  assign err_o = $signed({err[ErrW-1], err});

  // A negative difference truncates to zero or below, which the floor always lifts.
  always_comb begin
    priority if (diff[36]) begin
      drive_o = cfg_i.drive_floor;
    end else if (|diff[35:FracW+DriveW]) begin
      drive_o = DriveMax;
    end else if (quot < cfg_i.drive_floor) begin
      drive_o = cfg_i.drive_floor;
    end else begin
      drive_o = quot;
    end
  end

endmodule

// ===== hdl/pid_heater_drive_core.sv =====
// Each transaction passes the input register and then the result register; the integrator and
// last error update with the result; one transaction per cycle unless the output stalls.
// While a finished result waits on the output side, the input register takes one more
// transaction and then the input stalls until the result is taken.
// Reset (rst_ni low, asynchronous) clears both valid flags, the integrator and last error,
// and loads gains 20.0, 0, 20.0 and a drive floor of zero.
module pid_heater_drive_core import pid_hd_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  // measured_temp [15:0], target_temp [24:16], zeros [31:25]
  input  logic [InDataW-1:0]  s_axis_tdata,
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  // drive_value [9:0], zeros [15:10]
  output logic [OutDataW-1:0] m_axis_tdata
);

  cfg_t cfg;

  logic                     in_valid_q;
  logic signed [MeasW-1:0]  meas_q;
  logic [TargetW-1:0]       target_q;
  logic signed [IntegW-1:0] integ_q, integ_d;
  logic signed [PrevW-1:0]  prev_err_q, prev_err_d;
  logic                     out_valid_q;
  logic [DriveW-1:0]        drive_q, drive_d;
  logic                     out_free;
  logic                     fire;
  logic                     in_take;

  pid_hd_cfg u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  pid_hd_law u_law (
    .cfg_i      (cfg),
    .meas_i     (meas_q),
    .target_i   (target_q),
    .integ_i    (integ_q),
    .prev_err_i (prev_err_q),
    .integ_o    (integ_d),
    .err_o      (prev_err_d),
    .drive_o    (drive_d)
  );

  assign out_free      = !out_valid_q || m_axis_tready;
  assign fire          = in_valid_q && out_free;
  assign s_axis_tready = !in_valid_q || out_free;
  assign in_take       = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      integ_q     <= '0;
      prev_err_q  <= '0;
    end else begin
      if (s_axis_tready) begin
        in_valid_q <= s_axis_tvalid;
      end
      if (out_free) begin
        out_valid_q <= in_valid_q;
      end
      if (fire) begin
        integ_q    <= integ_d;
        prev_err_q <= prev_err_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      meas_q   <= $signed(s_axis_tdata[MeasW-1:0]);
      target_q <= s_axis_tdata[MeasW+TargetW-1:MeasW];
    end
    if (fire) begin
      drive_q <= drive_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {{(OutDataW-DriveW){1'b0}}, drive_q};

`ifndef NO_ASSERTIONS
  a_integ_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (integ_q <= IntegLimit) && (integ_q >= -IntegLimit))
    else $error("integrator left its clamp range");

  a_state_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !fire |=> $stable(integ_q) && $stable(prev_err_q))
    else $error("controller state changed without a transaction moving forward");

  a_fire_fills_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire |=> out_valid_q)
    else $error("result register empty after a transaction was computed");

  a_full_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_q && out_valid_q && !m_axis_tready) |-> !s_axis_tready)
    else $error("input accepted while both stages are full and stalled");
`endif

endmodule

// ===== bench/tb_pid_heater_drive_core.sv =====
// Self-checking bench for the PID heater drive core, with a drive predictor and stream handshakes.
module tb_pid_heater_drive_core;
  timeunit 1ns;
  timeprecision 1ps;

  import pid_hd_pkg::*;

  localparam int unsigned CycleLimit   = 200000;
  localparam int unsigned PhaseCnt     = 8;
  localparam int unsigned PhaseItems   = 210;
  localparam int unsigned HoldOffCycles = 300;

  typedef enum logic [1:0] {
    ROW_CFG,
    ROW_ITEM,
    ROW_CHECK
  } row_kind_e;

  typedef struct {
    row_kind_e               kind;
    cfg_reg_e                idx;
    logic [CfgDataW-1:0]     val;
    logic signed [MeasW-1:0] meas;
    logic [TargetW-1:0]      tgt;
    logic [DriveW-1:0]       drive;
  } dir_row_t;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx_i = '0;
  logic [CfgDataW-1:0] cfg_data_i = '0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [InDataW-1:0]  s_axis_tdata = '0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [OutDataW-1:0] m_axis_tdata;

  // Predictor copy of the configuration and the loop state.
  logic signed [GainW-1:0] k_p = GainPReset;
  logic signed [GainW-1:0] k_i = GainIReset;
  logic signed [GainW-1:0] k_d = GainDReset;
  logic [FloorW-1:0]       drive_floor_q = FloorReset;
  longint                  integ_acc = 0;
  longint                  last_err = 0;

  logic [DriveW-1:0] drive_q[$];
  logic [DriveW-1:0] want_drive;
  dir_row_t          dir_rows[$];

  int unsigned fail_cnt = 0;
  int unsigned items_sent = 0;
  int unsigned results_seen = 0;
  int unsigned settings_cnt = 1;
  int unsigned send_idle_pct = 38;
  int unsigned recv_idle_pct = 45;
  int unsigned stall_left = 0;
  bit          hold_req = 1'b0;
  bit          hold_done = 1'b0;

  pid_heater_drive_core i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  initial begin
    repeat (CycleLimit) @(posedge clk_i);
    $display("FAIL pid_heater_drive_core");
    $finish;
  end

  // One control tick: integrator update with clamp, then P and D terms on the unclamped sum.
  function automatic logic [DriveW-1:0] next_drive(logic signed [MeasW-1:0] meas,
                                                   logic [TargetW-1:0] tgt);
    longint err;
    longint acc;
    longint lim;
    longint drv;
    lim = longint'(IntegLimit);
    err = longint'(tgt) * 16 - longint'(meas);
    acc = integ_acc + longint'(k_i) * err;
    if (acc > lim) begin
      integ_acc = lim;
    end else if (acc < -lim) begin
      integ_acc = -lim;
    end else begin
      integ_acc = acc;
    end
    acc += longint'(k_p) * err + longint'(k_d) * (err - last_err);
    last_err = err;
    // Integer division truncates toward zero, which is the required rounding.
    drv = (longint'(DriveFull) - acc) / (longint'(1) << FracW);
    if (drv > longint'(DriveMax)) begin
      drv = longint'(DriveMax);
    end else if (drv < longint'(drive_floor_q)) begin
      drv = longint'(drive_floor_q);
    end
    return drv[DriveW-1:0];
  endfunction

  function automatic logic [GainW-1:0] mild_gain();
    return GainW'($urandom_range(1023, 0)) - GainW'(512);
  endfunction

  // Called and returns at a falling edge.
  task automatic write_reg(cfg_reg_e idx, logic [CfgDataW-1:0] val);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    case (idx)
      REG_GAIN_P: k_p = val;
      REG_GAIN_I: k_i = val;
      REG_GAIN_D: k_d = val;
      default:    drive_floor_q = val[FloorW-1:0];
    endcase
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    @(negedge clk_i);
  endtask

  // Leaves tvalid high on return so that back-to-back transactions stay possible.
  task automatic send_item(logic signed [MeasW-1:0] meas, logic [TargetW-1:0] tgt,
                           bit typed, logic [DriveW-1:0] typed_drive);
    logic [DriveW-1:0] pred;
    while ($urandom_range(99, 0) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {{(InDataW-TargetW-MeasW){1'b0}}, tgt, meas};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    pred = next_drive(meas, tgt);
    drive_q.push_back(typed ? typed_drive : pred);
    items_sent++;
    @(negedge clk_i);
  endtask

  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    while (drive_q.size() != 0) @(negedge clk_i);
  endtask

  task automatic set_phase_cfg(int unsigned p);
    logic [GainW-1:0]  gp;
    logic [GainW-1:0]  gi;
    logic [GainW-1:0]  gd;
    logic [FloorW-1:0] fl;
    gp = mild_gain();
    gi = mild_gain();
    gd = mild_gain();
    fl = FloorW'($urandom_range(1023, 0));
    case (p)
      0: fl = '0;
      1: begin
        gp = 16'h7FFF;
        gi = 16'h7FFF;
        gd = 16'h7FFF;
        fl = '0;
      end
      2: begin
        gp = 16'h8000;
        gi = 16'h8000;
        gd = 16'h8000;
        fl = 10'd500;
      end
      3: fl = 10'd500;
      4: begin
        gp = GainW'($urandom);
        gi = GainW'($urandom);
        gd = GainW'($urandom);
      end
      5: fl = DriveMax;
      7: fl = '0;
      default: ;
    endcase
    write_reg(REG_GAIN_P, gp);
    write_reg(REG_GAIN_I, gi);
    write_reg(REG_GAIN_D, gd);
    write_reg(REG_DRIVE_FLOOR, CfgDataW'(fl));
    settings_cnt++;
  endtask

  // Output side: random back-pressure plus one long hold-off on request.
  always @(negedge clk_i) begin
    if (stall_left != 0) begin
      stall_left = stall_left - 1;
      m_axis_tready <= 1'b0;
    end else if (hold_req && !hold_done) begin
      stall_left = HoldOffCycles;
      hold_done = 1'b1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99, 0) >= recv_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      results_seen++;
      if (drive_q.size() == 0) begin
        $display("%0t: drive result %0d arrived with nothing expected", $time, m_axis_tdata);
        fail_cnt++;
      end else begin
        want_drive = drive_q.pop_front();
        if (m_axis_tdata !== {{(OutDataW-DriveW){1'b0}}, want_drive}) begin
          $display("%0t: drive mismatch, expected %0d, got %0d", $time, want_drive,
                   m_axis_tdata);
          fail_cnt++;
        end
      end
    end
  end

  initial begin
    logic signed [MeasW-1:0] meas;
    logic [TargetW-1:0]      tgt;
    longint                  near;

    // Reset gains: P 20.0, I 0, D 20.0, floor 0.
    dir_rows.push_back('{ROW_CHECK, REG_GAIN_P, 16'd0, 16'sd0, 9'd0, 10'd1023});
    dir_rows.push_back('{ROW_CHECK, REG_GAIN_P, 16'd0, -16'sd32768, 9'd511, 10'd0});
    dir_rows.push_back('{ROW_CHECK, REG_GAIN_P, 16'd0, 16'sd32767, 9'd0, 10'd1023});
    dir_rows.push_back('{ROW_ITEM, REG_GAIN_P, 16'd0, 16'sh5555, 9'h0AA, 10'd0});
    dir_rows.push_back('{ROW_ITEM, REG_GAIN_P, 16'd0, -16'sh5556, 9'h155, 10'd0});
    dir_rows.push_back('{ROW_ITEM, REG_GAIN_P, 16'd0, 16'sd1600, 9'd100, 10'd0});
    // Unit proportional gain only, so the drive reads as 1023 - error in degrees.
    dir_rows.push_back('{ROW_CFG, REG_GAIN_P, 16'd256, 16'sd0, 9'd0, 10'd0});
    dir_rows.push_back('{ROW_CFG, REG_GAIN_D, 16'd0, 16'sd0, 9'd0, 10'd0});
    dir_rows.push_back('{ROW_CFG, REG_DRIVE_FLOOR, 16'd300, 16'sd0, 9'd0, 10'd0});
    // A drive of -0.5 truncates to zero and is then raised to the floor.
    dir_rows.push_back('{ROW_CHECK, REG_GAIN_P, 16'd0, -16'sd8200, 9'd511, 10'd300});
    dir_rows.push_back('{ROW_CFG, REG_DRIVE_FLOOR, 16'd0, 16'sd0, 9'd0, 10'd0});
    dir_rows.push_back('{ROW_CHECK, REG_GAIN_P, 16'd0, -16'sd8200, 9'd511, 10'd0});
    dir_rows.push_back('{ROW_CHECK, REG_GAIN_P, 16'd0, -16'sd8192, 9'd511, 10'd0});
    dir_rows.push_back('{ROW_CHECK, REG_GAIN_P, 16'd0, -16'sd8184, 9'd511, 10'd0});
    dir_rows.push_back('{ROW_CHECK, REG_GAIN_P, 16'd0, -16'sd8176, 9'd511, 10'd1});
    dir_rows.push_back('{ROW_CHECK, REG_GAIN_P, 16'd0, 16'sd8176, 9'd511, 10'd1023});
    dir_rows.push_back('{ROW_CHECK, REG_GAIN_P, 16'd0, 16'sd16, 9'd0, 10'd1023});
    // With the floor at full scale every drive is 1023.
    dir_rows.push_back('{ROW_CFG, REG_DRIVE_FLOOR, 16'd1023, 16'sd0, 9'd0, 10'd0});
    dir_rows.push_back('{ROW_CHECK, REG_GAIN_P, 16'd0, -16'sd32768, 9'd511, 10'd1023});
    dir_rows.push_back('{ROW_CHECK, REG_GAIN_P, 16'd0, 16'sd0, 9'd0, 10'd1023});
    // Extreme gains drive the integrator into both clamps.
    dir_rows.push_back('{ROW_CFG, REG_GAIN_I, 16'h7FFF, 16'sd0, 9'd0, 10'd0});
    dir_rows.push_back('{ROW_CFG, REG_GAIN_P, 16'h8000, 16'sd0, 9'd0, 10'd0});
    dir_rows.push_back('{ROW_CFG, REG_GAIN_D, 16'hFFFF, 16'sd0, 9'd0, 10'd0});
    dir_rows.push_back('{ROW_CFG, REG_DRIVE_FLOOR, 16'd0, 16'sd0, 9'd0, 10'd0});
    dir_rows.push_back('{ROW_ITEM, REG_GAIN_P, 16'd0, -16'sd32768, 9'd511, 10'd0});
    dir_rows.push_back('{ROW_ITEM, REG_GAIN_P, 16'd0, -16'sd32768, 9'd511, 10'd0});
    dir_rows.push_back('{ROW_ITEM, REG_GAIN_P, 16'd0, 16'sd32767, 9'd0, 10'd0});
    dir_rows.push_back('{ROW_ITEM, REG_GAIN_P, 16'd0, 16'sd32767, 9'd0, 10'd0});
    dir_rows.push_back('{ROW_ITEM, REG_GAIN_P, 16'd0, 16'sh7FF0, 9'h1FF, 10'd0});
    dir_rows.push_back('{ROW_CFG, REG_GAIN_I, 16'h8000, 16'sd0, 9'd0, 10'd0});
    dir_rows.push_back('{ROW_CFG, REG_GAIN_P, 16'h7FFF, 16'sd0, 9'd0, 10'd0});
    dir_rows.push_back('{ROW_CFG, REG_GAIN_D, 16'h7FFF, 16'sd0, 9'd0, 10'd0});
    dir_rows.push_back('{ROW_CFG, REG_DRIVE_FLOOR, 16'd500, 16'sd0, 9'd0, 10'd0});
    dir_rows.push_back('{ROW_ITEM, REG_GAIN_P, 16'd0, -16'sd32768, 9'd511, 10'd0});
    dir_rows.push_back('{ROW_ITEM, REG_GAIN_P, 16'd0, 16'sd32767, 9'd0, 10'd0});
    dir_rows.push_back('{ROW_ITEM, REG_GAIN_P, 16'd0, 16'sd100, 9'd7, 10'd0});
    dir_rows.push_back('{ROW_ITEM, REG_GAIN_P, 16'd0, 16'sd8176, 9'd511, 10'd0});

    repeat (7) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (dir_rows[i]) begin
      case (dir_rows[i].kind)
        ROW_CFG: begin
          drain_results();
          write_reg(dir_rows[i].idx, dir_rows[i].val);
          settings_cnt++;
        end
        ROW_ITEM:  send_item(dir_rows[i].meas, dir_rows[i].tgt, 1'b0, '0);
        default:   send_item(dir_rows[i].meas, dir_rows[i].tgt, 1'b1, dir_rows[i].drive);
      endcase
    end

    for (int unsigned p = 0; p < PhaseCnt; p++) begin
      drain_results();
      set_phase_cfg(p);
      if (p < 3) begin
        send_idle_pct = 38;
        recv_idle_pct = 45;
      end else if (p < 6) begin
        send_idle_pct = 45;
        recv_idle_pct = 38;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      if (p == 1) hold_req = 1'b1;
      for (int unsigned n = 0; n < PhaseItems; n++) begin
        tgt = TargetW'($urandom_range(511, 0));
        if ($urandom_range(9, 0) < 3) begin
          meas = MeasW'($urandom);
        end else begin
          // Mostly near the setpoint, within 64 degrees either side.
          near = longint'(tgt) * 16 + longint'($urandom_range(2047, 0)) - 1024;
          meas = near[MeasW-1:0];
        end
        send_item(meas, tgt, 1'b0, '0);
      end
    end

    drain_results();
    repeat (8) @(posedge clk_i);
    $display("Covered %0d samples under %0d gain/floor settings, %0d drive results checked.",
             items_sent, settings_cnt, results_seen);
    $display("Long output stall with input back-pressure: %0s.", hold_done ? "done" : "missed");
    if (fail_cnt == 0 && drive_q.size() == 0) begin
      $display("PASS pid_heater_drive_core");
    end else begin
      $display("FAIL pid_heater_drive_core");
    end
    $finish;
  end

endmodule
